@@ src/lemt_pkg.sv @@
// ----------------------------------------------------------------------------
// Listener endpoint match table - shared definitions
// Transaction types, request/response codes and the token that walks the
// cell chain.
// ----------------------------------------------------------------------------
package lemt_pkg;

    // Default number of table slots
    localparam int TABLE_DEPTH_DEF = 16;

    // Fixed field widths
    localparam int REQ_TYPE_W   = 3;
    localparam int ADDR_W       = 32;
    localparam int PORT_W       = 16;
    localparam int IFACE_W      = 8;
    localparam int HANDLE_W     = 16;
    localparam int STATUS_W     = 2;
    localparam int SLOT_IDX_W   = 4;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_INSERT   = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE   = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP   = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_CONFLICT = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_PORT_USE = 3'd4;

    // Response status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IN_USE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_MISS   = 2'd3;

    // Request transaction
    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [ADDR_W-1:0]     ip_addr;
        logic [PORT_W-1:0]     port_num;
        logic [IFACE_W-1:0]    iface_id;
        logic                  reuse_flag;
        logic [HANDLE_W-1:0]   owner_handle;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [HANDLE_W-1:0]   found_handle;
    } rsp_t;

    // Token passed from cell to cell; slot indexes travel beside it
    typedef struct packed {
        req_t                req;
        logic                ans_found;    // first-match answer taken
        logic                alt_found;    // free slot / wildcard seen
        logic [HANDLE_W-1:0] found_handle;
    } tok_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

endpackage

@@ src/lemt_cell.sv @@
// ----------------------------------------------------------------------------
// Listener endpoint match table - slot cell
// Holds one table slot, evaluates the passing token against it and hands the
// token on to the next cell through its token register.
// ----------------------------------------------------------------------------
module lemt_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tok_vld_i,
    input  lemt_pkg::tok_t     tok_i,
    input  logic [IDX_W-1:0]   ans_idx_i,
    input  logic [IDX_W-1:0]   alt_idx_i,
    output logic               tok_vld_o,
    output lemt_pkg::tok_t     tok_o,
    output logic [IDX_W-1:0]   ans_idx_o,
    output logic [IDX_W-1:0]   alt_idx_o,
    input  logic               commit_en_i,
    input  logic [IDX_W-1:0]   commit_idx_i,
    input  lemt_pkg::req_t     commit_data_i
);
    import lemt_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    // Slot storage
    logic                valid_reg, valid_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [PORT_W-1:0]   port_reg;
    logic [IFACE_W-1:0]  iface_reg;
    logic                reuse_reg;
    logic [HANDLE_W-1:0] handle_reg;

    // Token stage
    logic             tok_vld_reg;
    tok_t             tok_reg, tok_next;
    logic [IDX_W-1:0] ans_idx_reg, ans_idx_next;
    logic [IDX_W-1:0] alt_idx_reg, alt_idx_next;

    logic port_eq, addr_eq, iface_ok, iface_any, conflict, commit_hit;

    // Compare the slot against the request
    always_comb begin
        port_eq   = port_reg == tok_i.req.port_num;
        addr_eq   = addr_reg == tok_i.req.ip_addr;
        iface_ok  = (iface_reg == '0) || (tok_i.req.iface_id == '0) ||
                    (iface_reg == tok_i.req.iface_id);
        iface_any = (iface_reg == '0) || (iface_reg == tok_i.req.iface_id);
        conflict  = valid_reg && port_eq && iface_ok &&
                    (addr_eq ||
                     (((addr_reg == '0) || (tok_i.req.ip_addr == '0)) &&
                      !(reuse_reg && tok_i.req.reuse_flag)));
    end

    // Token update and slot release
    always_comb begin
        tok_next     = tok_i;
        ans_idx_next = ans_idx_i;
        alt_idx_next = alt_idx_i;
        valid_next   = valid_reg;
        if (tok_vld_i) begin
            case (tok_i.req.req_type)
                REQ_INSERT: begin
                    if (!tok_i.ans_found && conflict) begin
                        tok_next.ans_found = 1'b1;
                        ans_idx_next       = MY_IDX;
                    end
                    if (!tok_i.alt_found && !valid_reg) begin
                        tok_next.alt_found = 1'b1;
                        alt_idx_next       = MY_IDX;
                    end
                end
                REQ_REMOVE: begin
                    if (!tok_i.ans_found && valid_reg &&
                        handle_reg == tok_i.req.owner_handle) begin
                        tok_next.ans_found = 1'b1;
                        ans_idx_next       = MY_IDX;
                        valid_next         = 1'b0;
                    end
                end
                REQ_LOOKUP: begin
                    if (!tok_i.ans_found && valid_reg && port_eq && iface_any) begin
                        if (addr_eq) begin
                            tok_next.ans_found    = 1'b1;
                            tok_next.found_handle = handle_reg;
                            ans_idx_next          = MY_IDX;
                        end else if (addr_reg == '0) begin
                            // later wildcard replaces an earlier one
                            tok_next.alt_found    = 1'b1;
                            tok_next.found_handle = handle_reg;
                            alt_idx_next          = MY_IDX;
                        end
                    end
                end
                REQ_CONFLICT: begin
                    if (!tok_i.ans_found && conflict) begin
                        tok_next.ans_found = 1'b1;
                        ans_idx_next       = MY_IDX;
                    end
                end
                REQ_PORT_USE: begin
                    if (!tok_i.ans_found && valid_reg && port_eq) begin
                        tok_next.ans_found = 1'b1;
                        ans_idx_next       = MY_IDX;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign commit_hit = commit_en_i && (commit_idx_i == MY_IDX);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            tok_vld_reg <= 1'b0;
        end else begin
            valid_reg   <= commit_hit ? 1'b1 : valid_next;
            tok_vld_reg <= tok_vld_i;
        end
    end

    // Slot payload and token payload
    always_ff @(posedge aclk) begin
        tok_reg     <= tok_next;
        ans_idx_reg <= ans_idx_next;
        alt_idx_reg <= alt_idx_next;
        if (commit_hit) begin
            addr_reg   <= commit_data_i.ip_addr;
            port_reg   <= commit_data_i.port_num;
            iface_reg  <= commit_data_i.iface_id;
            reuse_reg  <= commit_data_i.reuse_flag;
            handle_reg <= commit_data_i.owner_handle;
        end
    end

    assign tok_vld_o = tok_vld_reg;
    assign tok_o     = tok_reg;
    assign ans_idx_o = ans_idx_reg;
    assign alt_idx_o = alt_idx_reg;

endmodule

@@ src/listener_endpoint_match_table_top.sv @@
// ----------------------------------------------------------------------------
// Listener endpoint match table - top level
// Table of listening endpoints with insert, remove, lookup and queries.
// ----------------------------------------------------------------------------
// Each slot lives in its own cell; a request enters the first cell on
// acceptance and moves one cell per clock, and the input takes the next
// request once the request has left the last cell and its result has gone
// to the output register. One request is in the chain at a time. An insert
// is written into its free slot as the request leaves the last cell. The
// result sits in an output register and a second holding register, so a new
// request is taken while a result waits in the output register, but not
// while one waits in the holding register. All slots are empty after reset.
module listener_endpoint_match_table_top #(
    parameter int TABLE_DEPTH = lemt_pkg::TABLE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lemt_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output lemt_pkg::rsp_t m_data
);
    import lemt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Chain wiring: element i feeds cell i, element TABLE_DEPTH is the tail
    logic             tok_vld [TABLE_DEPTH+1];
    tok_t             tok     [TABLE_DEPTH+1];
    logic [IDX_W-1:0] ans_idx [TABLE_DEPTH+1];
    logic [IDX_W-1:0] alt_idx [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] busy_vec;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    rsp_t   m_data_reg, m_data_next;
    rsp_t   pend_reg, pend_next;
    rsp_t   rsp_c;
    logic   commit_en, commit_ok;
    tok_t   tail;

    // Chain entry
    always_comb begin
        tok_vld[0]              = s_valid && s_ready;
        tok[0].req              = s_data;
        tok[0].ans_found        = 1'b0;
        tok[0].alt_found        = 1'b0;
        tok[0].found_handle     = '0;
        ans_idx[0]              = '0;
        alt_idx[0]              = '0;
    end

    // Cell chain
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        lemt_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .tok_vld_i     (tok_vld[i]),
            .tok_i         (tok[i]),
            .ans_idx_i     (ans_idx[i]),
            .alt_idx_i     (alt_idx[i]),
            .tok_vld_o     (tok_vld[i+1]),
            .tok_o         (tok[i+1]),
            .ans_idx_o     (ans_idx[i+1]),
            .alt_idx_o     (alt_idx[i+1]),
            .commit_en_i   (commit_en),
            .commit_idx_i  (alt_idx[TABLE_DEPTH]),
            .commit_data_i (tail.req)
        );
        assign busy_vec[i] = tok_vld[i+1];
    end

    assign tail = tok[TABLE_DEPTH];

    // Response from the token leaving the last cell
    always_comb begin
        rsp_c.status       = STAT_MISS;
        rsp_c.slot_index   = '0;
        rsp_c.found_handle = '0;
        commit_ok          = 1'b0;
        case (tail.req.req_type)
            REQ_INSERT: begin
                if (tail.ans_found) begin
                    rsp_c.status     = STAT_IN_USE;
                    rsp_c.slot_index = SLOT_IDX_W'(ans_idx[TABLE_DEPTH]);
                end else if (tail.alt_found) begin
                    rsp_c.status     = STAT_OK;
                    rsp_c.slot_index = SLOT_IDX_W'(alt_idx[TABLE_DEPTH]);
                    commit_ok        = 1'b1;
                end else begin
                    rsp_c.status     = STAT_FULL;
                end
            end
            REQ_REMOVE: begin
                if (tail.ans_found) begin
                    rsp_c.status     = STAT_OK;
                    rsp_c.slot_index = SLOT_IDX_W'(ans_idx[TABLE_DEPTH]);
                end
            end
            REQ_LOOKUP: begin
                if (tail.ans_found) begin
                    rsp_c.status       = STAT_OK;
                    rsp_c.slot_index   = SLOT_IDX_W'(ans_idx[TABLE_DEPTH]);
                    rsp_c.found_handle = tail.found_handle;
                end else if (tail.alt_found) begin
                    rsp_c.status       = STAT_OK;
                    rsp_c.slot_index   = SLOT_IDX_W'(alt_idx[TABLE_DEPTH]);
                    rsp_c.found_handle = tail.found_handle;
                end
            end
            REQ_CONFLICT, REQ_PORT_USE: begin
                if (tail.ans_found) begin
                    rsp_c.status     = STAT_IN_USE;
                    rsp_c.slot_index = SLOT_IDX_W'(ans_idx[TABLE_DEPTH]);
                end else begin
                    rsp_c.status     = STAT_OK;
                end
            end
            default: begin
            end
        endcase
    end

    // Controller: next state and output register
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pend_next    = pend_reg;
        commit_en    = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tok_vld[TABLE_DEPTH]) begin
                    commit_en = commit_ok;
                    if (!m_valid_reg || m_ready) begin
                        m_valid_next = 1'b1;
                        m_data_next  = rsp_c;
                        state_next   = S_IDLE;
                    end else begin
                        pend_next  = rsp_c;
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        pend_reg   <= pend_next;
    end

    // No request is taken while reset is held
    assign s_ready = (state_reg == S_IDLE) && aresetn;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // An accepted request always starts a scan
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_SCAN)
        else $error("accepted request did not start a scan");

    // At most one request travels the chain
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(busy_vec) <= 1)
        else $error("more than one request in the cell chain");

    // No request in flight while idle
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> busy_vec == '0)
        else $error("request in chain while idle");

    // A held result only exists behind a pending output
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_HOLD |-> m_valid_reg)
        else $error("holding a result with empty output register");

    // Slot writes only come from a successful insert
    a_commit_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        commit_en |-> tok_vld[TABLE_DEPTH] && tail.req.req_type == REQ_INSERT &&
                      !tail.ans_found)
        else $error("slot write without a successful insert");

endmodule
